### hdl/bilinear_rgb_sampler_defines.svh
// Assertion macros used by the sampler top level.
`ifndef BILINEAR_RGB_SAMPLER_DEFINES_SVH
`define BILINEAR_RGB_SAMPLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/bsr_pkg.sv
// Constants and types shared by the bilinear RGB sampler.
package bsr_pkg;

	localparam int unsigned MAX_WIDTH  = 1024;
	localparam int unsigned MAX_HEIGHT = 1024;
	localparam int unsigned FRAC_BITS  = 8;

	localparam int unsigned CH_W      = 8;
	localparam int unsigned NCH       = 3;
	localparam int unsigned PIX_W     = CH_W * NCH;
	localparam int unsigned PIX_IDX_W = 10;
	localparam int unsigned COORD_W   = 19;
	localparam int unsigned CFG_W     = 11;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned RST_SIZE  = 1024;

	localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
	localparam int unsigned ROW_W   = $clog2(MAX_HEIGHT);
	localparam int unsigned COLA_W  = (COL_W > 1) ? COL_W - 1 : 1;
	localparam int unsigned ROWA_W  = (ROW_W > 1) ? ROW_W - 1 : 1;
	localparam int unsigned BANK_AW = COLA_W + ROWA_W;
	localparam int unsigned NBANK   = 4;
	localparam int unsigned BANK_SEL_W = 2;

	localparam int unsigned INT_W  = COORD_W - 1 - FRAC_BITS;
	localparam int unsigned CMPX_W = ((INT_W > COL_W) ? INT_W : COL_W) + 1;
	localparam int unsigned CMPY_W = ((INT_W > ROW_W) ? INT_W : ROW_W) + 1;

	localparam int unsigned WGT_W  = FRAC_BITS + 1;
	localparam int unsigned TOP_W  = CH_W + FRAC_BITS;
	localparam int unsigned MUL1_W = TOP_W + 1;
	localparam int unsigned MUL2_W = TOP_W + FRAC_BITS + 1;
	localparam logic [WGT_W-1:0] SCALE = WGT_W'(1 << FRAC_BITS);

	localparam logic [COL_W-1:0] W_LAST_RST =
		COL_W'(((RST_SIZE > MAX_WIDTH) ? MAX_WIDTH : RST_SIZE) - 1);
	localparam logic [ROW_W-1:0] H_LAST_RST =
		ROW_W'(((RST_SIZE > MAX_HEIGHT) ? MAX_HEIGHT : RST_SIZE) - 1);

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	// Decoded item after the address stage.
	typedef struct packed {
		logic                             sample;
		logic                             wr_en;
		logic [BANK_SEL_W-1:0]            wbank;
		logic [PIX_W-1:0]                 wdata;
		logic [NBANK-1:0][BANK_AW-1:0]    addr;
		logic                             x0b;
		logic                             x1b;
		logic                             y0b;
		logic                             y1b;
		logic [FRAC_BITS-1:0]             fx;
		logic [FRAC_BITS-1:0]             fy;
	} s1_t;

	// Bank read data with the neighbour parity and the fractions.
	typedef struct packed {
		logic [NBANK-1:0][PIX_W-1:0] pix;
		logic                        x0b;
		logic                        x1b;
		logic                        y0b;
		logic                        y1b;
		logic [FRAC_BITS-1:0]        fx;
		logic [FRAC_BITS-1:0]        fy;
	} s2_t;

	typedef struct packed {
		logic adv_s3;
		logic adv_s4;
	} blend_ctrl_t;

endpackage

### hdl/bsr_if.sv
// Input and output channel interfaces of the sampler.
interface bsr_in_if;
	logic                              valid;
	logic                              ready;
	logic                              mode;
	logic [bsr_pkg::PIX_IDX_W-1:0]     pixel_col;
	logic [bsr_pkg::PIX_IDX_W-1:0]     pixel_row;
	logic [bsr_pkg::CH_W-1:0]          red_in;
	logic [bsr_pkg::CH_W-1:0]          green_in;
	logic [bsr_pkg::CH_W-1:0]          blue_in;
	logic signed [bsr_pkg::COORD_W-1:0] sample_x;
	logic signed [bsr_pkg::COORD_W-1:0] sample_y;

	modport source (
		output valid, mode, pixel_col, pixel_row, red_in, green_in, blue_in,
		output sample_x, sample_y,
		input  ready
	);
	modport sink (
		input  valid, mode, pixel_col, pixel_row, red_in, green_in, blue_in,
		input  sample_x, sample_y,
		output ready
	);
endinterface

interface bsr_out_if;
	logic                     valid;
	logic                     ready;
	logic [bsr_pkg::CH_W-1:0] red;
	logic [bsr_pkg::CH_W-1:0] green;
	logic [bsr_pkg::CH_W-1:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

### hdl/bsr_ram.sv
// Generic single-port RAM with registered read data.
module bsr_ram #(
	parameter int unsigned ADDR_W = 8,
	parameter int unsigned DATA_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

### hdl/bsr_addr.sv
// Size registers, coordinate clamp and bank address stage.
module bsr_addr (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bsr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bsr_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              load,
	input  logic                              mode,
	input  logic [bsr_pkg::PIX_IDX_W-1:0]     pixel_col,
	input  logic [bsr_pkg::PIX_IDX_W-1:0]     pixel_row,
	input  logic [bsr_pkg::CH_W-1:0]          red_in,
	input  logic [bsr_pkg::CH_W-1:0]          green_in,
	input  logic [bsr_pkg::CH_W-1:0]          blue_in,
	input  logic signed [bsr_pkg::COORD_W-1:0] sample_x,
	input  logic signed [bsr_pkg::COORD_W-1:0] sample_y,
	output bsr_pkg::s1_t                      s1
);

	logic [bsr_pkg::COL_W-1:0]   wlast_q;
	logic [bsr_pkg::ROW_W-1:0]   hlast_q;
	logic [bsr_pkg::COL_W-1:0]   last_w;
	logic [bsr_pkg::ROW_W-1:0]   last_h;

	logic [bsr_pkg::COORD_W-2:0] sx_pos;
	logic [bsr_pkg::COORD_W-2:0] sy_pos;
	logic [bsr_pkg::CMPX_W-1:0]  xi_e;
	logic [bsr_pkg::CMPX_W-1:0]  wl_e;
	logic [bsr_pkg::CMPY_W-1:0]  yi_e;
	logic [bsr_pkg::CMPY_W-1:0]  hl_e;
	logic [bsr_pkg::COL_W-1:0]   x0;
	logic [bsr_pkg::COL_W-1:0]   x1;
	logic [bsr_pkg::ROW_W-1:0]   y0;
	logic [bsr_pkg::ROW_W-1:0]   y1;
	logic [bsr_pkg::COL_W-1:0]   wcol;
	logic [bsr_pkg::ROW_W-1:0]   wrow;
	logic [bsr_pkg::COL_W-1:0]   bcol;
	logic [bsr_pkg::ROW_W-1:0]   brow;
	bsr_pkg::s1_t                s1_d;

	// Zero acts as one, anything past the store acts as the store size.
	always_comb begin
		if (cfg_data == '0) begin
			last_w = '0;
		end else if (32'(cfg_data) > bsr_pkg::MAX_WIDTH) begin
			last_w = bsr_pkg::COL_W'(bsr_pkg::MAX_WIDTH - 1);
		end else begin
			last_w = bsr_pkg::COL_W'(cfg_data - bsr_pkg::CFG_W'(1));
		end
		if (cfg_data == '0) begin
			last_h = '0;
		end else if (32'(cfg_data) > bsr_pkg::MAX_HEIGHT) begin
			last_h = bsr_pkg::ROW_W'(bsr_pkg::MAX_HEIGHT - 1);
		end else begin
			last_h = bsr_pkg::ROW_W'(cfg_data - bsr_pkg::CFG_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q <= bsr_pkg::W_LAST_RST;
			hlast_q <= bsr_pkg::H_LAST_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bsr_pkg::REG_IMAGE_WIDTH:  wlast_q <= last_w;
				bsr_pkg::REG_IMAGE_HEIGHT: hlast_q <= last_h;
				default: ;
			endcase
		end
	end

	always_comb begin
		// Negative positions clamp to zero before the split.
		sx_pos = sample_x[bsr_pkg::COORD_W-1] ? '0 : sample_x[bsr_pkg::COORD_W-2:0];
		sy_pos = sample_y[bsr_pkg::COORD_W-1] ? '0 : sample_y[bsr_pkg::COORD_W-2:0];

		xi_e = bsr_pkg::CMPX_W'(sx_pos[bsr_pkg::COORD_W-2:bsr_pkg::FRAC_BITS]);
		wl_e = bsr_pkg::CMPX_W'(wlast_q);
		yi_e = bsr_pkg::CMPY_W'(sy_pos[bsr_pkg::COORD_W-2:bsr_pkg::FRAC_BITS]);
		hl_e = bsr_pkg::CMPY_W'(hlast_q);

		x0 = (xi_e > wl_e) ? wlast_q : bsr_pkg::COL_W'(xi_e);
		x1 = (xi_e >= wl_e) ? wlast_q : bsr_pkg::COL_W'(xi_e + bsr_pkg::CMPX_W'(1));
		y0 = (yi_e > hl_e) ? hlast_q : bsr_pkg::ROW_W'(yi_e);
		y1 = (yi_e >= hl_e) ? hlast_q : bsr_pkg::ROW_W'(yi_e + bsr_pkg::CMPY_W'(1));

		wcol = bsr_pkg::COL_W'(pixel_col);
		wrow = bsr_pkg::ROW_W'(pixel_row);

		s1_d.sample = mode;
		s1_d.wr_en  = !mode && (32'(pixel_col) < bsr_pkg::MAX_WIDTH)
			&& (32'(pixel_row) < bsr_pkg::MAX_HEIGHT);
		s1_d.wbank  = {wrow[0], wcol[0]};
		s1_d.wdata  = {blue_in, green_in, red_in};
		s1_d.x0b    = x0[0];
		s1_d.x1b    = x1[0];
		s1_d.y0b    = y0[0];
		s1_d.y1b    = y1[0];
		s1_d.fx     = sx_pos[bsr_pkg::FRAC_BITS-1:0];
		s1_d.fy     = sy_pos[bsr_pkg::FRAC_BITS-1:0];

		// Bank {row parity, col parity} serves whichever neighbour has that parity.
		for (int b = 0; b < bsr_pkg::NBANK; b++) begin
			bcol = (x0[0] == b[0]) ? x0 : x1;
			brow = (y0[0] == b[1]) ? y0 : y1;
			if (!mode) begin
				bcol = wcol;
				brow = wrow;
			end
			s1_d.addr[b] = {bsr_pkg::ROWA_W'(brow >> 1), bsr_pkg::COLA_W'(bcol >> 1)};
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			s1 <= s1_d;
		end
	end

endmodule

### hdl/bsr_blend.sv
// Horizontal then vertical blend stages for the three channels.
module bsr_blend (
	input  logic                      clk,
	input  bsr_pkg::blend_ctrl_t      ctrl,
	input  bsr_pkg::s2_t              s2,
	output logic [bsr_pkg::CH_W-1:0]  red,
	output logic [bsr_pkg::CH_W-1:0]  green,
	output logic [bsr_pkg::CH_W-1:0]  blue
);

	logic [bsr_pkg::PIX_W-1:0]                        p00;
	logic [bsr_pkg::PIX_W-1:0]                        p01;
	logic [bsr_pkg::PIX_W-1:0]                        p10;
	logic [bsr_pkg::PIX_W-1:0]                        p11;
	logic [bsr_pkg::WGT_W-1:0]                        wx;
	logic [bsr_pkg::WGT_W-1:0]                        fxe;
	logic [bsr_pkg::WGT_W-1:0]                        wy;
	logic [bsr_pkg::WGT_W-1:0]                        fye;
	logic [bsr_pkg::NCH-1:0][bsr_pkg::TOP_W-1:0]      top_d;
	logic [bsr_pkg::NCH-1:0][bsr_pkg::TOP_W-1:0]      bot_d;
	logic [bsr_pkg::NCH-1:0][bsr_pkg::TOP_W-1:0]      top_s3;
	logic [bsr_pkg::NCH-1:0][bsr_pkg::TOP_W-1:0]      bot_s3;
	logic [bsr_pkg::FRAC_BITS-1:0]                    fy_s3;
	logic [bsr_pkg::NCH-1:0][bsr_pkg::MUL2_W-1:0]     sum;
	logic [bsr_pkg::NCH-1:0][bsr_pkg::CH_W-1:0]       chan_d;
	logic [bsr_pkg::NCH-1:0][bsr_pkg::CH_W-1:0]       chan_s4;

	always_comb begin
		p00 = s2.pix[{s2.y0b, s2.x0b}];
		p01 = s2.pix[{s2.y0b, s2.x1b}];
		p10 = s2.pix[{s2.y1b, s2.x0b}];
		p11 = s2.pix[{s2.y1b, s2.x1b}];
		fxe = bsr_pkg::WGT_W'(s2.fx);
		wx  = bsr_pkg::SCALE - fxe;
		for (int c = 0; c < bsr_pkg::NCH; c++) begin
			top_d[c] = bsr_pkg::TOP_W'(
				bsr_pkg::MUL1_W'(p00[c*bsr_pkg::CH_W +: bsr_pkg::CH_W]) * bsr_pkg::MUL1_W'(wx)
				+ bsr_pkg::MUL1_W'(p01[c*bsr_pkg::CH_W +: bsr_pkg::CH_W])
				* bsr_pkg::MUL1_W'(fxe));
			bot_d[c] = bsr_pkg::TOP_W'(
				bsr_pkg::MUL1_W'(p10[c*bsr_pkg::CH_W +: bsr_pkg::CH_W]) * bsr_pkg::MUL1_W'(wx)
				+ bsr_pkg::MUL1_W'(p11[c*bsr_pkg::CH_W +: bsr_pkg::CH_W])
				* bsr_pkg::MUL1_W'(fxe));
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv_s3) begin
			top_s3 <= top_d;
			bot_s3 <= bot_d;
			fy_s3  <= s2.fy;
		end
	end

	// Exact product, then drop both fraction fields.
	always_comb begin
		fye = bsr_pkg::WGT_W'(fy_s3);
		wy  = bsr_pkg::SCALE - fye;
		for (int c = 0; c < bsr_pkg::NCH; c++) begin
			sum[c] = bsr_pkg::MUL2_W'(top_s3[c]) * bsr_pkg::MUL2_W'(wy)
				+ bsr_pkg::MUL2_W'(bot_s3[c]) * bsr_pkg::MUL2_W'(fye);
			chan_d[c] = sum[c][2*bsr_pkg::FRAC_BITS +: bsr_pkg::CH_W];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv_s4) begin
			chan_s4 <= chan_d;
		end
	end

	assign red   = chan_s4[0];
	assign green = chan_s4[1];
	assign blue  = chan_s4[2];

endmodule

### hdl/bilinear_rgb_sampler.sv
// Bilinear RGB sampler top level: flow control, banked frame store, blend.
// A sample result passes the address, bank read, horizontal blend and output registers in turn.
// One transaction per cycle unless the output stalls; four parity banks each serve one read.
// Each stage moves on when it is empty or the one after it moves, so bubbles fill under stall.
// Reset clears valid bits and sets both image sizes to 1024; the frame store is not cleared.
`include "bilinear_rgb_sampler_defines.svh"

module bilinear_rgb_sampler (
	input  logic                          clk,
	input  logic                          arst_n,
	bsr_in_if.sink                        in_ch,
	bsr_out_if.source                     out_ch,
	input  logic                          cfg_we,
	input  logic [bsr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bsr_pkg::CFG_W-1:0]     cfg_data
);

	logic                                         valid_s1;
	logic                                         valid_s2;
	logic                                         valid_s3;
	logic                                         valid_s4;
	logic                                         adv_s1;
	logic                                         adv_s2;
	logic                                         adv_s3;
	logic                                         adv_s4;
	bsr_pkg::s1_t                                 s1;
	bsr_pkg::s2_t                                 s2;
	bsr_pkg::blend_ctrl_t                         bctrl;
	logic [bsr_pkg::NBANK-1:0][bsr_pkg::PIX_W-1:0] rdata;
	logic                                         x0b_s2;
	logic                                         x1b_s2;
	logic                                         y0b_s2;
	logic                                         y1b_s2;
	logic [bsr_pkg::FRAC_BITS-1:0]                fx_s2;
	logic [bsr_pkg::FRAC_BITS-1:0]                fy_s2;

	assign adv_s4 = !valid_s4 || out_ch.ready;
	assign adv_s3 = !valid_s3 || adv_s4;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !valid_s1 || adv_s2;

	assign in_ch.ready  = adv_s1;
	assign out_ch.valid = valid_s4;

	// Write transactions end at the store and carry no valid past it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_ch.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1 && s1.sample;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
			if (adv_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	bsr_addr u_addr (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.load      (adv_s1),
		.mode      (in_ch.mode),
		.pixel_col (in_ch.pixel_col),
		.pixel_row (in_ch.pixel_row),
		.red_in    (in_ch.red_in),
		.green_in  (in_ch.green_in),
		.blue_in   (in_ch.blue_in),
		.sample_x  (in_ch.sample_x),
		.sample_y  (in_ch.sample_y),
		.s1        (s1)
	);

	for (genvar b = 0; b < bsr_pkg::NBANK; b++) begin : g_bank
		bsr_ram #(
			.ADDR_W (bsr_pkg::BANK_AW),
			.DATA_W (bsr_pkg::PIX_W)
		) u_ram (
			.clk   (clk),
			.we    (adv_s2 && valid_s1 && s1.wr_en
				&& (s1.wbank == bsr_pkg::BANK_SEL_W'(b))),
			.re    (adv_s2),
			.addr  (s1.addr[b]),
			.wdata (s1.wdata),
			.rdata (rdata[b])
		);
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			x0b_s2 <= s1.x0b;
			x1b_s2 <= s1.x1b;
			y0b_s2 <= s1.y0b;
			y1b_s2 <= s1.y1b;
			fx_s2  <= s1.fx;
			fy_s2  <= s1.fy;
		end
	end

	always_comb begin
		s2.pix = rdata;
		s2.x0b = x0b_s2;
		s2.x1b = x1b_s2;
		s2.y0b = y0b_s2;
		s2.y1b = y1b_s2;
		s2.fx  = fx_s2;
		s2.fy  = fy_s2;
		bctrl.adv_s3 = adv_s3;
		bctrl.adv_s4 = adv_s4;
	end

	bsr_blend u_blend (
		.clk   (clk),
		.ctrl  (bctrl),
		.s2    (s2),
		.red   (out_ch.red),
		.green (out_ch.green),
		.blue  (out_ch.blue)
	);

	`BSR_ASSERT_NOW(a_stall_only_when_full, clk, arst_n, !in_ch.ready, valid_s1 && valid_s2 && valid_s3 && valid_s4, "input stalled while a stage is empty")
	`BSR_ASSERT_NEXT(a_write_drops, clk, arst_n, adv_s2 && !(valid_s1 && s1.sample), !valid_s2, "non-sample transaction passed the store")
	`BSR_ASSERT_NEXT(a_s3_hold, clk, arst_n, valid_s3 && !adv_s3, valid_s3, "blend stage lost a transaction under stall")
	`BSR_ASSERT_NEXT(a_s4_load, clk, arst_n, adv_s4 && valid_s3, valid_s4, "output stage failed to take a result")

endmodule

### sim/tb_bilinear_rgb_sampler.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bilinear RGB sampler: pixel writes, samples, image sizes.
module tb_bilinear_rgb_sampler;

	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;
	localparam int   SCL         = 1 << bsr_pkg::FRAC_BITS;
	localparam int   COORD_MAX   = (1 << (bsr_pkg::COORD_W - 1)) - 1;
	localparam int   COORD_MIN   = -(1 << (bsr_pkg::COORD_W - 1));
	localparam int   DRAIN_SLACK = 8;
	localparam int   LIMIT_CYCLES = 600000;
	localparam int   MAX_REPORTS = 100;

	typedef logic signed [bsr_pkg::COORD_W-1:0] coord_t;

	typedef struct packed {
		logic [bsr_pkg::CH_W-1:0] red;
		logic [bsr_pkg::CH_W-1:0] green;
		logic [bsr_pkg::CH_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic                          mode;
		logic [bsr_pkg::PIX_IDX_W-1:0] col;
		logic [bsr_pkg::PIX_IDX_W-1:0] row;
		logic [bsr_pkg::CH_W-1:0]      red;
		logic [bsr_pkg::CH_W-1:0]      green;
		logic [bsr_pkg::CH_W-1:0]      blue;
		coord_t                        sx;
		coord_t                        sy;
	} pixel_op_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [bsr_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bsr_pkg::CFG_W-1:0]     cfg_data;

	bsr_in_if  in_ch ();
	bsr_out_if out_ch ();

	bilinear_rgb_sampler u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow of the frame store and the size registers.
	logic [bsr_pkg::PIX_W-1:0] frame_mem [int unsigned];
	logic [bsr_pkg::CFG_W-1:0] width_reg;
	logic [bsr_pkg::CFG_W-1:0] height_reg;
	rgb_t                      rgb_expect_q [$];

	int errors;
	int accepted_items;
	int tx_idle_pct;
	int rx_idle_pct;
	int hold_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		for (int n = 0; n < LIMIT_CYCLES; n++)
			@(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int unsigned eff_size(logic [bsr_pkg::CFG_W-1:0] r, int unsigned maxv);
		if (r == '0)
			return 1;
		if (32'(r) > maxv)
			return maxv;
		return 32'(r);
	endfunction

	function automatic int unsigned int_part(coord_t c);
		return (c < 0) ? 0 : 32'(c[bsr_pkg::COORD_W-2:bsr_pkg::FRAC_BITS]);
	endfunction

	function automatic int unsigned frac_part(coord_t c);
		return (c < 0) ? 0 : 32'(c[bsr_pkg::FRAC_BITS-1:0]);
	endfunction

	function automatic int unsigned edge_clamp(int unsigned i, int unsigned size);
		return (i >= size) ? size - 1 : i;
	endfunction

	function automatic int unsigned pix_addr(int unsigned col, int unsigned row);
		return row * bsr_pkg::MAX_WIDTH + col;
	endfunction

	function automatic logic [bsr_pkg::CH_W-1:0] blend_ch(logic [bsr_pkg::CH_W-1:0] a,
			logic [bsr_pkg::CH_W-1:0] b, logic [bsr_pkg::CH_W-1:0] c,
			logic [bsr_pkg::CH_W-1:0] d, int unsigned fx, int unsigned fy);
		int unsigned top, bot;
		top = 32'(a) * (SCL - fx) + 32'(b) * fx;
		bot = 32'(c) * (SCL - fx) + 32'(d) * fx;
		return bsr_pkg::CH_W'((top * (SCL - fy) + bot * fy) >> (2 * bsr_pkg::FRAC_BITS));
	endfunction

	function automatic rgb_t predict_rgb(coord_t sx, coord_t sy);
		int unsigned w, h, fx, fy, c0, c1, r0, r1;
		logic [bsr_pkg::PIX_W-1:0] p00, p01, p10, p11;
		rgb_t res;
		w  = eff_size(width_reg, bsr_pkg::MAX_WIDTH);
		h  = eff_size(height_reg, bsr_pkg::MAX_HEIGHT);
		fx = frac_part(sx);
		fy = frac_part(sy);
		c0 = edge_clamp(int_part(sx), w);
		c1 = edge_clamp(int_part(sx) + 1, w);
		r0 = edge_clamp(int_part(sy), h);
		r1 = edge_clamp(int_part(sy) + 1, h);
		p00 = frame_mem[pix_addr(c0, r0)];
		p01 = frame_mem[pix_addr(c1, r0)];
		p10 = frame_mem[pix_addr(c0, r1)];
		p11 = frame_mem[pix_addr(c1, r1)];
		res.red   = blend_ch(p00[7:0], p01[7:0], p10[7:0], p11[7:0], fx, fy);
		res.green = blend_ch(p00[15:8], p01[15:8], p10[15:8], p11[15:8], fx, fy);
		res.blue  = blend_ch(p00[23:16], p01[23:16], p10[23:16], p11[23:16], fx, fy);
		return res;
	endfunction

	// Random coordinate around the image, from two pixels before it to one pixel past its far side.
	function automatic int near_coord(int unsigned size);
		int v;
		v = int'($urandom_range(0, (size + 2) * SCL)) - 2 * SCL;
		if (v > COORD_MAX)
			v = COORD_MAX;
		return v;
	endfunction

	task automatic send_item(input pixel_op_t op);
		if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.mode      <= op.mode;
		in_ch.pixel_col <= op.col;
		in_ch.pixel_row <= op.row;
		in_ch.red_in    <= op.red;
		in_ch.green_in  <= op.green;
		in_ch.blue_in   <= op.blue;
		in_ch.sample_x  <= op.sx;
		in_ch.sample_y  <= op.sy;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		accepted_items++;
		if (op.mode == MODE_WRITE)
			frame_mem[pix_addr(32'(op.col), 32'(op.row))] = {op.blue, op.green, op.red};
		else
			rgb_expect_q.insert(rgb_expect_q.size(), predict_rgb(op.sx, op.sy));
	endtask

	task automatic write_pixel(input int unsigned col, input int unsigned row,
			input int unsigned r, input int unsigned g, input int unsigned b);
		pixel_op_t op;
		op.mode  = MODE_WRITE;
		op.col   = bsr_pkg::PIX_IDX_W'(col);
		op.row   = bsr_pkg::PIX_IDX_W'(row);
		op.red   = bsr_pkg::CH_W'(r);
		op.green = bsr_pkg::CH_W'(g);
		op.blue  = bsr_pkg::CH_W'(b);
		op.sx    = coord_t'($urandom);
		op.sy    = coord_t'($urandom);
		send_item(op);
	endtask

	// Fill any of the four neighbours that has never been written.
	task automatic fill_neighbours(input coord_t sx, input coord_t sy);
		int unsigned w, h;
		int unsigned cols [2];
		int unsigned rows [2];
		w = eff_size(width_reg, bsr_pkg::MAX_WIDTH);
		h = eff_size(height_reg, bsr_pkg::MAX_HEIGHT);
		cols[0] = edge_clamp(int_part(sx), w);
		cols[1] = edge_clamp(int_part(sx) + 1, w);
		rows[0] = edge_clamp(int_part(sy), h);
		rows[1] = edge_clamp(int_part(sy) + 1, h);
		foreach (rows[j])
			foreach (cols[i])
				if (!frame_mem.exists(pix_addr(cols[i], rows[j])))
					write_pixel(cols[i], rows[j], $urandom, $urandom, $urandom);
	endtask

	task automatic sample_at(input int sx, input int sy);
		coord_t    csx, csy;
		pixel_op_t op;
		csx = coord_t'(sx);
		csy = coord_t'(sy);
		fill_neighbours(csx, csy);
		op.mode  = MODE_SAMPLE;
		op.col   = bsr_pkg::PIX_IDX_W'($urandom);
		op.row   = bsr_pkg::PIX_IDX_W'($urandom);
		op.red   = bsr_pkg::CH_W'($urandom);
		op.green = bsr_pkg::CH_W'($urandom);
		op.blue  = bsr_pkg::CH_W'($urandom);
		op.sx    = csx;
		op.sy    = csy;
		send_item(op);
	endtask

	// Drop valid, wait for every pending result, then let in-flight writes retire.
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (rgb_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic set_size(input int unsigned w, input int unsigned h);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= bsr_pkg::REG_IMAGE_WIDTH;
		cfg_data  <= bsr_pkg::CFG_W'(w);
		@(posedge clk);
		cfg_index <= bsr_pkg::REG_IMAGE_HEIGHT;
		cfg_data  <= bsr_pkg::CFG_W'(h);
		@(posedge clk);
		cfg_we     <= 1'b0;
		width_reg  = bsr_pkg::CFG_W'(w);
		height_reg = bsr_pkg::CFG_W'(h);
	endtask

	task automatic test_reset_sizes();
		sample_at(0, 0);
		sample_at(COORD_MAX, COORD_MAX);
		sample_at(COORD_MIN, COORD_MIN);
		sample_at(COORD_MIN, 3 * SCL + 77);
	endtask

	task automatic test_pixel_extremes();
		write_pixel(1022, 1022, 255, 255, 255);
		write_pixel(1023, 1022, 0, 0, 0);
		write_pixel(1022, 1023, 255, 0, 128);
		write_pixel(1023, 1023, 0, 255, 127);
		sample_at(1022 * SCL + SCL - 1, 1022 * SCL + SCL - 1);
		sample_at(1022 * SCL, 1022 * SCL);
		sample_at(1022 * SCL + SCL / 2, 1022 * SCL + 1);
	endtask

	task automatic test_register_extremes();
		// Zero acts as one: every sample lands on pixel (0,0).
		set_size(0, 0);
		sample_at(SCL + SCL - 1, 2 * SCL + SCL - 1);
		sample_at(-1, COORD_MAX);
		// Oversize acts as the maximum.
		set_size((1 << bsr_pkg::CFG_W) - 1, (1 << bsr_pkg::CFG_W) - 1);
		sample_at(COORD_MAX, SCL / 2);
		set_size(1, bsr_pkg::MAX_HEIGHT);
		sample_at(1000 * SCL, 1023 * SCL + 77);
		set_size(bsr_pkg::MAX_WIDTH, 1);
		sample_at(1023 * SCL + 200, 5 * SCL + 3);
	endtask

	task automatic test_backpressure();
		set_size(8, 8);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		for (int i = 0; i < 64; i++)
			write_pixel(i % 8, i / 8, $urandom, $urandom, $urandom);
		hold_req = 300;
		for (int i = 0; i < 60; i++)
			sample_at(near_coord(8), near_coord(8));
		wait_idle();
	endtask

	task automatic run_random(input int n_items);
		int first, pick;
		int unsigned w, h;
		first = accepted_items;
		w = eff_size(width_reg, bsr_pkg::MAX_WIDTH);
		h = eff_size(height_reg, bsr_pkg::MAX_HEIGHT);
		while (accepted_items - first < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				sample_at(near_coord(w), near_coord(h));
			else if (pick < 70)
				sample_at(int'($urandom), int'($urandom));
			else if (pick < 85)
				write_pixel($urandom_range(0, w - 1), $urandom_range(0, h - 1),
					$urandom, $urandom, $urandom);
			else
				write_pixel($urandom, $urandom, $urandom, $urandom, $urandom);
		end
	endtask

	task automatic test_random_phases();
		int unsigned w, h;
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin
					w = $urandom_range(1, 8);
					h = $urandom_range(1, 8);
					tx_idle_pct = 25;
					rx_idle_pct = 25;
				end
				1: begin
					w = bsr_pkg::MAX_WIDTH;
					h = bsr_pkg::MAX_HEIGHT;
					tx_idle_pct = 0;
					rx_idle_pct = 15;
				end
				2: begin
					w = $urandom_range(2, 32);
					h = 1;
					tx_idle_pct = 15;
					rx_idle_pct = 0;
				end
				3: begin
					w = 1;
					h = $urandom_range(2, 32);
					tx_idle_pct = 30;
					rx_idle_pct = 30;
				end
				4: begin
					w = $urandom_range(bsr_pkg::MAX_WIDTH + 1, (1 << bsr_pkg::CFG_W) - 1);
					h = 0;
					tx_idle_pct = 10;
					rx_idle_pct = 20;
				end
				5: begin
					w = $urandom_range(1, bsr_pkg::MAX_WIDTH);
					h = $urandom_range(1, bsr_pkg::MAX_HEIGHT);
					tx_idle_pct = 20;
					rx_idle_pct = 10;
				end
				default: begin
					w = $urandom_range(2, 16);
					h = $urandom_range(2, 16);
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			set_size(w, h);
			run_random(230);
		end
	endtask

	// Result sink: random stall bursts plus long hold-offs on request.
	initial begin : result_sink
		int rx_hold;
		out_ch.ready = 1'b0;
		rx_hold = 0;
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				rx_hold  = hold_req;
				hold_req = 0;
			end
			if (rx_hold != 0) begin
				out_ch.ready <= 1'b0;
				rx_hold--;
			end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
				out_ch.ready <= 1'b0;
				rx_hold = $urandom_range(0, 9);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		rgb_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (rgb_expect_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result, expected none, actual %0d %0d %0d",
						$time, out_ch.red, out_ch.green, out_ch.blue);
			end else begin
				want = rgb_expect_q.pop_front();
				if (out_ch.red !== want.red) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: red mismatch, expected %0d actual %0d",
							$time, want.red, out_ch.red);
				end
				if (out_ch.green !== want.green) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: green mismatch, expected %0d actual %0d",
							$time, want.green, out_ch.green);
				end
				if (out_ch.blue !== want.blue) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: blue mismatch, expected %0d actual %0d",
							$time, want.blue, out_ch.blue);
				end
			end
		end
	end

	initial begin
		errors          = 0;
		accepted_items  = 0;
		tx_idle_pct     = 20;
		rx_idle_pct     = 20;
		hold_req        = 0;
		width_reg       = bsr_pkg::CFG_W'(bsr_pkg::RST_SIZE);
		height_reg      = bsr_pkg::CFG_W'(bsr_pkg::RST_SIZE);
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = bsr_pkg::REG_IMAGE_WIDTH;
		cfg_data        = '0;
		in_ch.valid     = 1'b0;
		in_ch.mode      = MODE_WRITE;
		in_ch.pixel_col = '0;
		in_ch.pixel_row = '0;
		in_ch.red_in    = '0;
		in_ch.green_in  = '0;
		in_ch.blue_in   = '0;
		in_ch.sample_x  = '0;
		in_ch.sample_y  = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_sizes();
		test_pixel_extremes();
		test_register_extremes();
		test_backpressure();
		test_random_phases();

		wait_idle();
		repeat (10) @(posedge clk);
		if (errors == 0 && rgb_expect_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### sim.f
+incdir+hdl
hdl/bsr_pkg.sv
hdl/bsr_if.sv
hdl/bsr_ram.sv
hdl/bsr_addr.sv
hdl/bsr_blend.sv
hdl/bilinear_rgb_sampler.sv
sim/tb_bilinear_rgb_sampler.sv
